// ===== design/vwbp_pkg.sv =====
package vwbp_pkg;

    // Field widths
    localparam int VALUE_BITS = 32;
    localparam int WORD_BITS  = 64;
    localparam int CFG_BITS   = 6;

    // Width register limits and reset value
    localparam logic [CFG_BITS-1:0] BPV_RESET = 6'd4;
    localparam logic [CFG_BITS-1:0] MIN_WIDTH = 6'd1;
    localparam logic [CFG_BITS-1:0] MAX_WIDTH = 6'd32;

    // One classified value on its way to the packer
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;  // already masked to width
        logic [CFG_BITS-1:0]   width;  // 1..32
        logic                  last;
    } item_t;

    // One packed word on its way out
    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic                 last;
    } word_t;

endpackage

// ===== design/vwbp_queue.sv =====
module vwbp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and count update, pointers wrap at DEPTH
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/vwbp_front.sv =====
module vwbp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [vwbp_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vwbp_pkg::VALUE_BITS-1:0]     s_value,
    input  logic                                s_last_value,
    output logic                                q_push,
    output vwbp_pkg::item_t                     q_item,
    input  logic                                q_full
);

    logic [vwbp_pkg::CFG_BITS-1:0]   bpv_reg;
    logic [vwbp_pkg::CFG_BITS-1:0]   width;
    logic [vwbp_pkg::VALUE_BITS:0]   mask_wide;
    vwbp_pkg::item_t                 item_reg, item_next;
    logic                            valid_reg;

    // Clamp configured width into 1..32
    always_comb begin
        if (bpv_reg == '0) begin
            width = vwbp_pkg::MIN_WIDTH;
        end else if (bpv_reg > vwbp_pkg::MAX_WIDTH) begin
            width = vwbp_pkg::MAX_WIDTH;
        end else begin
            width = bpv_reg;
        end
    end

    // Mask value to width
    always_comb begin
        mask_wide        = ((vwbp_pkg::VALUE_BITS+1)'(1) << width)
                           - (vwbp_pkg::VALUE_BITS+1)'(1);
        item_next.value  = s_value & mask_wide[vwbp_pkg::VALUE_BITS-1:0];
        item_next.width  = width;
        item_next.last   = s_last_value;
    end

    assign s_ready = !valid_reg || !q_full;
    assign q_push  = valid_reg;
    assign q_item  = item_reg;

    // Width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpv_reg <= vwbp_pkg::BPV_RESET;
        end else if (cfg_wr_en) begin
            bpv_reg <= cfg_wr_data;
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/vwbp_back.sv =====
module vwbp_back #(
    parameter int WORD_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               item_valid,
    input  vwbp_pkg::item_t                    item,
    output logic                               item_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vwbp_pkg::WORD_BITS-1:0]     m_packed_word,
    output logic                               m_last_word
);

    localparam int WB = vwbp_pkg::WORD_BITS;
    localparam int FILL_W = $clog2(WB);

    logic [WB-1:0]      acc_reg, acc_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               pend_valid_reg, pend_valid_next;
    vwbp_pkg::word_t    pend_reg, pend_next;

    logic [FILL_W:0]    total;
    logic [2*WB-1:0]    wide;
    logic [WB-1:0]      merged;
    logic [WB-1:0]      high;
    logic               word_done;
    logic [FILL_W-1:0]  new_fill;

    logic               oq_push, oq_full;
    vwbp_pkg::word_t    oq_data, oq_head;

    // Shift value into place across two words
    always_comb begin
        total     = {1'b0, fill_reg} + (FILL_W+1)'(item.width);
        wide      = (2*WB)'(item.value) << fill_reg;
        merged    = acc_reg | wide[WB-1:0];
        high      = wide[2*WB-1:WB];
        word_done = total[FILL_W];
        new_fill  = total[FILL_W-1:0];
    end

    assign item_pop = item_valid && !pend_valid_reg && !oq_full;

    // Packing control
    always_comb begin
        acc_next        = acc_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        oq_push         = 1'b0;
        oq_data         = '0;
        if (pend_valid_reg) begin
            // second word of a last value that straddled
            if (!oq_full) begin
                oq_push         = 1'b1;
                oq_data         = pend_reg;
                pend_valid_next = 1'b0;
            end
        end else if (item_pop) begin
            if (word_done) begin
                oq_push      = 1'b1;
                oq_data.data = merged;
                oq_data.last = item.last && (new_fill == '0);
                acc_next     = high;
                fill_next    = new_fill;
                if (item.last && (new_fill != '0)) begin
                    pend_valid_next = 1'b1;
                    pend_next.data  = high;
                    pend_next.last  = 1'b1;
                end
            end else begin
                acc_next  = merged;
                fill_next = new_fill;
                if (item.last) begin
                    oq_push      = 1'b1;
                    oq_data.data = merged;
                    oq_data.last = 1'b1;
                end
            end
            if (item.last) begin
                acc_next  = '0;
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            acc_reg        <= acc_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    // Output word queue, head drives the result channel
    vwbp_queue #(
        .DATA_W ($bits(vwbp_pkg::word_t)),
        .DEPTH  (WORD_DEPTH)
    ) u_word_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (oq_push),
        .push_data (oq_data),
        .full      (oq_full),
        .pop       (m_ready),
        .pop_data  (oq_head),
        .not_empty (m_valid)
    );

    assign m_packed_word = oq_head.data;
    assign m_last_word   = oq_head.last;

endmodule

// ===== design/variable_width_bit_packer.sv =====
// Variable-width bit packer, LSB first, into 64-bit words.
// Input channel (s_valid/s_ready): one value per request, masked to the
// configured width (cfg_wr_data, 1..32; 0 acts as 1, above 32 acts as 32)
// and appended above the bits already held. s_last_value ends the array.
// Result channel (m_valid/m_ready): one packed 64-bit word per request.
// A word goes out each time 64 bits have gathered; on the last value any
// partial word follows with its upper bits zero, and the final word of the
// array carries m_last_word. The packer then starts a fresh word.
// Throughput: one value per cycle while m_ready stays high. A last value
// that both completes a word and leaves a remainder emits two words, and
// the packer takes no new value until the second has entered the output
// queue. Path: a value passes the input stage, the item queue and the
// packer into the output queue before its word is offered.
// Stalls: a low m_ready fills the output queue, then the packer stops and
// the item queue absorbs further values until s_ready drops.
// Reset (aresetn low, synchronous): queues empty, accumulator cleared,
// width register back to 4. Write the width only while the block is idle.
module variable_width_bit_packer #(
    parameter int ITEM_DEPTH = 4,
    parameter int WORD_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vwbp_pkg::CFG_BITS-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vwbp_pkg::VALUE_BITS-1:0]   s_value,
    input  logic                              s_last_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vwbp_pkg::WORD_BITS-1:0]    m_packed_word,
    output logic                              m_last_word
);

    logic            fq_push, fq_full;
    vwbp_pkg::item_t fq_in;
    logic            iq_valid, iq_pop;
    vwbp_pkg::item_t iq_head;

    // Front: width clamp, masking, input stage
    vwbp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_last_value (s_last_value),
        .q_push       (fq_push),
        .q_item       (fq_in),
        .q_full       (fq_full)
    );

    // Queue between front and packer
    vwbp_queue #(
        .DATA_W ($bits(vwbp_pkg::item_t)),
        .DEPTH  (ITEM_DEPTH)
    ) u_item_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fq_push),
        .push_data (fq_in),
        .full      (fq_full),
        .pop       (iq_pop),
        .pop_data  (iq_head),
        .not_empty (iq_valid)
    );

    // Back: accumulator and word output
    vwbp_back #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (iq_valid),
        .item          (iq_head),
        .item_pop      (iq_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_last_word   (m_last_word)
    );

endmodule

// ===== sim/variable_width_bit_packer_tb.sv =====
`timescale 1ns / 1ps

module variable_width_bit_packer_tb;

    // Expected-word tracker: mirrors the packer state and queues the words it owes
    class packer_scoreboard;
        logic [vwbp_pkg::CFG_BITS-1:0]  width_reg;
        logic [vwbp_pkg::WORD_BITS-1:0] acc;
        int unsigned                    fill;
        vwbp_pkg::word_t                pending[$];
        int                             errors;

        function new();
            width_reg = vwbp_pkg::BPV_RESET;
            acc       = '0;
            fill      = 0;
            errors    = 0;
        endfunction

        function void set_width(logic [vwbp_pkg::CFG_BITS-1:0] w);
            width_reg = w;
        endfunction

        // Pack one accepted value and queue any words it completes
        function void note_value(logic [vwbp_pkg::VALUE_BITS-1:0] v, logic lst);
            logic [vwbp_pkg::WORD_BITS-1:0] mask;
            logic [vwbp_pkg::WORD_BITS-1:0] bits;
            int unsigned                    eff;
            int unsigned                    total;
            bit                             emitted;
            vwbp_pkg::word_t                w;

            // 0 acts as 1, anything over 32 acts as 32
            if (width_reg < vwbp_pkg::MIN_WIDTH)
                eff = 32'(vwbp_pkg::MIN_WIDTH);
            else if (width_reg > vwbp_pkg::MAX_WIDTH)
                eff = 32'(vwbp_pkg::MAX_WIDTH);
            else
                eff = 32'(width_reg);

            mask    = (64'd1 << eff) - 64'd1;
            bits    = {32'd0, v} & mask;
            total   = fill + eff;
            emitted = 1'b0;
            acc     = acc | (bits << fill);

            if (total >= vwbp_pkg::WORD_BITS) begin
                w.data  = acc;
                w.last  = 1'b0;
                pending.push_back(w);
                emitted = 1'b1;
                // spill the bits that did not fit into the next word
                acc  = (total > vwbp_pkg::WORD_BITS) ?
                       (bits >> (vwbp_pkg::WORD_BITS - fill)) : '0;
                fill = total - vwbp_pkg::WORD_BITS;
            end else begin
                fill = total;
            end

            // last value: flush a partial word, or flag the exact-fill word
            if (lst) begin
                if (fill != 0) begin
                    w.data = acc;
                    w.last = 1'b1;
                    pending.push_back(w);
                end else if (emitted) begin
                    pending[pending.size()-1].last = 1'b1;
                end
                acc  = '0;
                fill = 0;
            end
        endfunction

        function void check_word(logic [vwbp_pkg::WORD_BITS-1:0] d, logic l);
            vwbp_pkg::word_t exp_word;

            if (pending.size() == 0) begin
                $display("%0t: unexpected word, actual data %h last %b", $time, d, l);
                errors++;
                return;
            end
            exp_word = pending.pop_front();
            if (exp_word.data !== d) begin
                $display("%0t: packed_word mismatch, expected %h actual %h",
                         $time, exp_word.data, d);
                errors++;
            end
            if (exp_word.last !== l) begin
                $display("%0t: last_word mismatch, expected %b actual %b",
                         $time, exp_word.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn      = 1'b0;
    logic                            cfg_wr_en    = 1'b0;
    logic [vwbp_pkg::CFG_BITS-1:0]   cfg_wr_data  = '0;
    logic                            s_valid      = 1'b0;
    logic                            s_ready;
    logic [vwbp_pkg::VALUE_BITS-1:0] s_value      = '0;
    logic                            s_last_value = 1'b0;
    logic                            m_valid;
    logic                            m_ready      = 1'b0;
    logic [vwbp_pkg::WORD_BITS-1:0]  m_packed_word;
    logic                            m_last_word;

    int                              src_idle_pct   = 0;
    int                              sink_stall_pct = 0;
    packer_scoreboard                board;

    variable_width_bit_packer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_value  (s_last_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_word (m_packed_word),
        .m_last_word   (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_packed_word, m_last_word);
    end

    // Offer one value; returns at the edge where the request is taken
    task automatic send_value(input logic [vwbp_pkg::VALUE_BITS-1:0] v, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value      <= v;
        s_last_value <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_value(v, lst);
    endtask

    // Drain all owed words, then give values that emit nothing time to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(input logic [vwbp_pkg::CFG_BITS-1:0] w);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_width(w);
    endtask

    initial begin
        logic [vwbp_pkg::CFG_BITS-1:0]   w;
        logic [vwbp_pkg::VALUE_BITS-1:0] v;
        int                              sent;
        int                              len;
        int                              k;

        board = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset width, extremes, exact fill, two-word last, mid-array write
        send_value(32'hFFFF_FFFF, 1'b1);
        write_width(vwbp_pkg::MAX_WIDTH);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h1234_5678, 1'b1);
        send_value(32'h0000_0000, 1'b1);
        write_width(6'd0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'hFFFF_FFFE, 1'b1);
        write_width(6'd63);
        send_value(32'hA5A5_A5A5, 1'b0);
        send_value(32'h5A5A_5A5A, 1'b1);
        write_width(6'd20);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h000A_BCDE, 1'b0);
        send_value(32'hFFF1_2345, 1'b0);
        send_value(32'h0006_789A, 1'b1);
        write_width(6'd7);
        send_value(32'hFFFF_FF81, 1'b0);
        send_value(32'h0000_007F, 1'b0);
        send_value(32'h0000_0055, 1'b0);
        write_width(6'd13);
        for (k = 0; k < 4; k++)
            send_value($urandom, k == 3);

        // Random: three idling profiles, several widths each
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct   = 32;
                    sink_stall_pct = 50;
                end
                1: begin
                    src_idle_pct   = 50;
                    sink_stall_pct = 32;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 6; ph++) begin
                case (ph)
                    0:       w = vwbp_pkg::MIN_WIDTH;
                    1:       w = vwbp_pkg::MAX_WIDTH;
                    2:       w = 6'd0;
                    3:       w = 6'd63;
                    4:       w = 6'($urandom_range(vwbp_pkg::MAX_WIDTH, vwbp_pkg::MIN_WIDTH));
                    default: w = 6'($urandom_range(63, 0));
                endcase
                write_width(w);
                sent = 0;
                while (sent < 64) begin
                    len = $urandom_range(40, 1);
                    for (k = 0; k < len; k++) begin
                        case ($urandom_range(9))
                            0:       v = '1;
                            1:       v = '0;
                            default: v = $urandom;
                        endcase
                        send_value(v, k == len - 1);
                    end
                    sent += len;
                end
                // sometimes leave an array open across the width change
                if ($urandom_range(2) == 0) begin
                    len = $urandom_range(10, 1);
                    for (k = 0; k < len; k++)
                        send_value($urandom, 1'b0);
                end
            end
        end

        wait_idle();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
